FILE: rtl/bcpe_pkg.sv
package bcpe_pkg;

    // Field widths.
    localparam int unsigned PARAM_W = 17;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned POINT_W = 64;
    localparam int unsigned IDX_W   = 3;

    // Number of register stages from input to output.
    localparam int unsigned NUM_STAGES = 9;

    // The value 1.0 of the curve parameter in Q1.16.
    localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

    // Half of one output LSB in the final Q.64 sum, for round to nearest.
    localparam logic [79:0] ROUND_HALF = 80'h0000_0000_8000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_POINT_ZERO  = 3'd1,
        REG_POINT_ONE   = 3'd2,
        REG_POINT_TWO   = 3'd3,
        REG_POINT_THREE = 3'd4
    } cfg_index_t;

    // Control point counts.
    localparam logic [IDX_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [IDX_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [IDX_W-1:0] CNT_THREE = 3'd3;
    localparam logic [IDX_W-1:0] CNT_FOUR  = 3'd4;

    typedef logic [PARAM_W-1:0]        param_t;
    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

FILE: rtl/bezier_curve_point_eval_core.sv
// Bezier curve point evaluator, orders 0 to 3, two dimensions.
// Configuration: a write channel (cfg_valid/cfg_ready, cfg_index, cfg_data).
// Index 0 sets the number of control points, indexes 1 to 4 set the points
// P0..P3 (x in bits 31:0, y in bits 63:32, signed Q16.16). cfg_ready is
// always high; other indexes are ignored. Write only while the block is idle.
// Input channel: curve_param (t in Q1.16, values above 1.0 saturate) with
// in_valid/in_stall. Output channel: point_x, point_y with out_valid/out_stall.
// The curve is evaluated by three exact de Casteljau levels, each of the form
// Q = A*2^16 + t*(B - A); levels beyond the curve order use t = 0 and so only
// scale. Wide levels split their multiply into two partial products over two
// stages. Throughput is one beat per cycle while the output is not stalled.
// Each stage holds its beat when the next stage is full and cannot move, so
// bubbles close up under a stall and no beat is lost or repeated; in_stall is
// raised only when every stage is full and the output is stalled.
// Reset clears all valid bits and the configuration registers (count 0, which
// gives the origin).
module bezier_curve_point_eval_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcpe_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bcpe_pkg::POINT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bcpe_pkg::PARAM_W-1:0]  curve_param,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [bcpe_pkg::COORD_W-1:0] point_x,
    output logic signed [bcpe_pkg::COORD_W-1:0] point_y
);

    localparam int unsigned NS = bcpe_pkg::NUM_STAGES;

    // Configuration registers.
    logic [bcpe_pkg::IDX_W-1:0]   count_reg;
    logic [bcpe_pkg::POINT_W-1:0] pt_reg [4];
    bcpe_pkg::coord_t             coord [2][4];

    // Stage control.
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    // Stage 0: saturated parameter selected per level.
    bcpe_pkg::param_t t_sat;
    bcpe_pkg::param_t s0_t1_reg, s0_t2_reg, s0_t3_reg;
    logic             s0_zero_reg;

    // Stage 1: first level.
    logic signed [47:0] s1_q_next [2][3];
    logic signed [47:0] s1_q_reg  [2][3];
    bcpe_pkg::param_t   s1_t2_reg, s1_t3_reg;
    logic               s1_zero_reg;

    // Stage 2: second level differences.
    logic signed [48:0] s2_d_next [2][2];
    logic signed [48:0] s2_d_reg  [2][2];
    logic signed [47:0] s2_q_reg  [2][2];
    bcpe_pkg::param_t   s2_t2_reg, s2_t3_reg;
    logic               s2_zero_reg;

    // Stage 3: second level partial products.
    logic [40:0]        s3_pl_next [2][2];
    logic signed [42:0] s3_ph_next [2][2];
    logic [40:0]        s3_pl_reg  [2][2];
    logic signed [42:0] s3_ph_reg  [2][2];
    logic signed [47:0] s3_q_reg   [2][2];
    bcpe_pkg::param_t   s3_t3_reg;
    logic               s3_zero_reg;

    // Stage 4: second level sums.
    logic signed [63:0] s4_r_next [2][2];
    logic signed [63:0] s4_r_reg  [2][2];
    bcpe_pkg::param_t   s4_t3_reg;
    logic               s4_zero_reg;

    // Stage 5: third level difference.
    logic signed [64:0] s5_d_next [2];
    logic signed [64:0] s5_d_reg  [2];
    logic signed [63:0] s5_r_reg  [2];
    bcpe_pkg::param_t   s5_t3_reg;
    logic               s5_zero_reg;

    // Stage 6: third level partial products.
    logic [48:0]        s6_pl_next [2];
    logic signed [50:0] s6_ph_next [2];
    logic [48:0]        s6_pl_reg  [2];
    logic signed [50:0] s6_ph_reg  [2];
    logic signed [63:0] s6_r_reg   [2];
    logic               s6_zero_reg;

    // Stage 7: full sum scaled by 2^48.
    logic [79:0] s7_s_next [2];
    logic [79:0] s7_s_reg  [2];
    logic        s7_zero_reg;

    // Stage 8: rounded output.
    logic [79:0]      s8_round [2];
    bcpe_pkg::coord_t s8_pt_next [2];
    bcpe_pkg::coord_t s8_pt_reg  [2];

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                pt_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcpe_pkg::REG_POINT_COUNT: count_reg <= cfg_data[bcpe_pkg::IDX_W-1:0];
                bcpe_pkg::REG_POINT_ZERO:  pt_reg[0] <= cfg_data;
                bcpe_pkg::REG_POINT_ONE:   pt_reg[1] <= cfg_data;
                bcpe_pkg::REG_POINT_TWO:   pt_reg[2] <= cfg_data;
                bcpe_pkg::REG_POINT_THREE: pt_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Split the packed points into coordinates: dimension 0 is x, 1 is y.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            coord[0][i] = pt_reg[i][31:0];
            coord[1][i] = pt_reg[i][63:32];
        end
    end

    // A stage may load when it is empty or when its beat moves on.
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: saturate t and choose which levels interpolate.
    assign t_sat = (curve_param > bcpe_pkg::ONE_Q16) ? bcpe_pkg::ONE_Q16 : curve_param;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_t1_reg <= (count_reg inside {[bcpe_pkg::CNT_TWO:bcpe_pkg::CNT_FOUR]})
                         ? t_sat : '0;
            s0_t2_reg <= (count_reg inside {[bcpe_pkg::CNT_THREE:bcpe_pkg::CNT_FOUR]})
                         ? t_sat : '0;
            s0_t3_reg <= (count_reg == bcpe_pkg::CNT_FOUR) ? t_sat : '0;
            s0_zero_reg <= !(count_reg inside {[bcpe_pkg::CNT_ONE:bcpe_pkg::CNT_FOUR]});
        end
    end

    // Stage 1: Q = P(i)*2^16 + t*(P(i+1) - P(i)).
    always_comb
    begin
        logic signed [32:0] diff;
        logic signed [50:0] prod;
        logic signed [50:0] sum;
        for (int d = 0; d < 2; d++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff = {coord[d][i+1][31], coord[d][i+1]} - {coord[d][i][31], coord[d][i]};
                prod = $signed({1'b0, s0_t1_reg}) * diff;
                sum  = {{3{coord[d][i][31]}}, coord[d][i], 16'h0000} + prod;
                s1_q_next[d][i] = sum[47:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_q_reg    <= s1_q_next;
            s1_t2_reg   <= s0_t2_reg;
            s1_t3_reg   <= s0_t3_reg;
            s1_zero_reg <= s0_zero_reg;
        end
    end

    // Stage 2: second level differences.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s2_d_next[d][i] = {s1_q_reg[d][i+1][47], s1_q_reg[d][i+1]}
                                - {s1_q_reg[d][i][47], s1_q_reg[d][i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_d_reg    <= s2_d_next;
            for (int d = 0; d < 2; d++)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    s2_q_reg[d][i] <= s1_q_reg[d][i];
                end
            end
            s2_t2_reg   <= s1_t2_reg;
            s2_t3_reg   <= s1_t3_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    // Stage 3: t times the difference, split into a low and a high half.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s3_pl_next[d][i] = s2_t2_reg * s2_d_reg[d][i][23:0];
                s3_ph_next[d][i] = $signed({1'b0, s2_t2_reg}) * $signed(s2_d_reg[d][i][48:24]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_pl_reg   <= s3_pl_next;
            s3_ph_reg   <= s3_ph_next;
            s3_q_reg    <= s2_q_reg;
            s3_t3_reg   <= s2_t3_reg;
            s3_zero_reg <= s2_zero_reg;
        end
    end

    // Stage 4: R = Q(i)*2^16 + high*2^24 + low, exact in 64 bits.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s4_r_next[d][i] = {s3_q_reg[d][i], 16'h0000}
                                + {s3_ph_reg[d][i][39:0], 24'h000000}
                                + {23'h000000, s3_pl_reg[d][i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_r_reg    <= s4_r_next;
            s4_t3_reg   <= s3_t3_reg;
            s4_zero_reg <= s3_zero_reg;
        end
    end

    // Stage 5: third level difference.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            s5_d_next[d] = {s4_r_reg[d][1][63], s4_r_reg[d][1]}
                         - {s4_r_reg[d][0][63], s4_r_reg[d][0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_d_reg <= s5_d_next;
            for (int d = 0; d < 2; d++)
            begin
                s5_r_reg[d] <= s4_r_reg[d][0];
            end
            s5_t3_reg   <= s4_t3_reg;
            s5_zero_reg <= s4_zero_reg;
        end
    end

    // Stage 6: third level partial products.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            s6_pl_next[d] = s5_t3_reg * s5_d_reg[d][31:0];
            s6_ph_next[d] = $signed({1'b0, s5_t3_reg}) * $signed(s5_d_reg[d][64:32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_pl_reg   <= s6_pl_next;
            s6_ph_reg   <= s6_ph_next;
            s6_r_reg    <= s5_r_reg;
            s6_zero_reg <= s5_zero_reg;
        end
    end

    // Stage 7: full weighted sum, scaled by 2^48.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            s7_s_next[d] = {s6_r_reg[d], 16'h0000}
                         + {s6_ph_reg[d][47:0], 32'h0000_0000}
                         + {31'h0000_0000, s6_pl_reg[d]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_s_reg    <= s7_s_next;
            s7_zero_reg <= s6_zero_reg;
        end
    end

    // Stage 8: round to nearest, ties upward, or force the origin.
    always_comb
    begin
        for (int d = 0; d < 2; d++)
        begin
            s8_round[d]   = s7_s_reg[d] + bcpe_pkg::ROUND_HALF;
            s8_pt_next[d] = s7_zero_reg ? '0 : s8_round[d][79:48];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_pt_reg <= s8_pt_next;
        end
    end

    assign point_x = s8_pt_reg[0];
    assign point_y = s8_pt_reg[1];

endmodule
